>>> src/qrrs_pkg.sv
// constants, widths and status codes of the quadratic real-root solver
// no dependencies
package qrrs_pkg;

	localparam int COEF_W  = 16;
	localparam int ROOT_W  = 32;
	localparam int STAT_W  = 2;
	localparam int DISC_W  = 35;
	localparam int RAD_W   = 50;
	localparam int SQ_W    = 25;
	localparam int SQR_W   = 27;
	localparam int NUM_W   = 27;
	localparam int MAG_W   = 33;
	localparam int QDIV_W  = 33;

	localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_A_ZERO  = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_NO_REAL = 2'd2;

endpackage

>>> src/quadratic_real_root_solver.sv
// Quadratic real-root solver: takes a, b, c in signed Q8.8 and returns both real roots in
// signed Q16.16 with a status and a saturation flag. One coefficient set is taken per
// cycle unless the output stalls; the pipeline holds the 25-step square root and the
// 33-step divisions, one bit per pipeline stage. A stall on the output holds the whole
// pipeline, and s_axis_tready follows m_axis_tready while a result waits.
// Depends on qrrs_pkg.
module quadratic_real_root_solver import qrrs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // coef_a, coef_b, coef_c
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // root_plus, root_minus
	output logic [2:0]  m_axis_tuser   // solve_status, root_saturated
);

	logic en;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: products
	logic                     v_s1;
	logic signed [COEF_W-1:0] a_s1, b_s1;
	logic signed [31:0]       bb_s1, ac_s1;

	// stage 2: discriminant
	logic                     v_s2;
	logic signed [COEF_W-1:0] a_s2, b_s2;
	logic signed [DISC_W-1:0] d_s2;
	logic [STAT_W-1:0]        st_s2;

	// square root stages
	logic                     sq_v   [0:SQ_W];
	logic [RAD_W-1:0]         sq_rad [0:SQ_W];
	logic [SQR_W-1:0]         sq_rem [0:SQ_W];
	logic [SQ_W-1:0]          sq_rt  [0:SQ_W];
	logic signed [COEF_W-1:0] sq_a   [0:SQ_W];
	logic signed [COEF_W-1:0] sq_b   [0:SQ_W];
	logic [STAT_W-1:0]        sq_st  [0:SQ_W];

	// division stages, plus and minus roots side by side
	logic                dv_v   [0:QDIV_W];
	logic [MAG_W-1:0]    dv_ddp [0:QDIV_W];
	logic [MAG_W-1:0]    dv_ddm [0:QDIV_W];
	logic [COEF_W-1:0]   dv_rp  [0:QDIV_W];
	logic [COEF_W-1:0]   dv_rm  [0:QDIV_W];
	logic [QDIV_W-1:0]   dv_qp  [0:QDIV_W];
	logic [QDIV_W-1:0]   dv_qm  [0:QDIV_W];
	logic [COEF_W-1:0]   dv_dvs [0:QDIV_W];
	logic                dv_np  [0:QDIV_W];
	logic                dv_nm  [0:QDIV_W];
	logic [STAT_W-1:0]   dv_st  [0:QDIV_W];

	// output stage
	logic              v_out_q;
	logic [ROOT_W-1:0] rp_q, rm_q;
	logic [STAT_W-1:0] st_q;
	logic              sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= $signed(s_axis_tdata[15:0]);
			b_s1  <= $signed(s_axis_tdata[31:16]);
			bb_s1 <= $signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[31:16]);
			ac_s1 <= $signed(s_axis_tdata[15:0]) * $signed(s_axis_tdata[47:32]);
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			d_s2  <= $signed({{3{bb_s1[31]}}, bb_s1}) - $signed({ac_s1[31], ac_s1, 2'b00});
			if (a_s1 == '0)
				st_s2 <= STATUS_A_ZERO;
			else if ($signed({{3{bb_s1[31]}}, bb_s1}) < $signed({ac_s1[31], ac_s1, 2'b00}))
				st_s2 <= STATUS_NO_REAL;
			else
				st_s2 <= STATUS_OK;
		end
	end

	// square root, one result bit per stage
	always_comb begin
		sq_v[0]   = v_s2;
		sq_rad[0] = {d_s2[33:0], 16'd0};
		sq_rem[0] = '0;
		sq_rt[0]  = '0;
		sq_a[0]   = a_s2;
		sq_b[0]   = b_s2;
		sq_st[0]  = st_s2;
	end

	for (genvar i = 0; i < SQ_W; i++) begin : g_sqrt
		logic [SQR_W+1:0] t;
		logic [SQR_W+1:0] trial;
		logic             ge;
		logic [SQR_W+1:0] diff;
		assign t     = {sq_rem[i], sq_rad[i][RAD_W-1 -: 2]};
		assign trial = {2'b00, sq_rt[i], 2'b01};
		assign ge    = t >= trial;
		assign diff  = t - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v[i+1] <= 1'b0;
			else if (en)
				sq_v[i+1] <= sq_v[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad[i+1] <= {sq_rad[i][RAD_W-3:0], 2'b00};
				sq_rem[i+1] <= ge ? diff[SQR_W-1:0] : t[SQR_W-1:0];
				sq_rt[i+1]  <= {sq_rt[i][SQ_W-2:0], ge};
				sq_a[i+1]   <= sq_a[i];
				sq_b[i+1]   <= sq_b[i];
				sq_st[i+1]  <= sq_st[i];
			end
		end
	end

	// numerators and their magnitudes
	logic signed [NUM_W-1:0] nb, np, nm, abs_p, abs_m;
	always_comb begin
		nb    = -($signed({{(NUM_W-COEF_W){sq_b[SQ_W][COEF_W-1]}}, sq_b[SQ_W]}) <<< 8);
		np    = nb + $signed({2'b00, sq_rt[SQ_W]});
		nm    = nb - $signed({2'b00, sq_rt[SQ_W]});
		abs_p = np[NUM_W-1] ? -np : np;
		abs_m = nm[NUM_W-1] ? -nm : nm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v[0] <= 1'b0;
		else if (en)
			dv_v[0] <= sq_v[SQ_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_ddp[0] <= {abs_p[25:0], 7'd0};
			dv_ddm[0] <= {abs_m[25:0], 7'd0};
			dv_rp[0]  <= '0;
			dv_rm[0]  <= '0;
			dv_qp[0]  <= '0;
			dv_qm[0]  <= '0;
			dv_dvs[0] <= sq_a[SQ_W][COEF_W-1] ? COEF_W'(-sq_a[SQ_W]) : sq_a[SQ_W];
			dv_np[0]  <= np[NUM_W-1] ^ sq_a[SQ_W][COEF_W-1];
			dv_nm[0]  <= nm[NUM_W-1] ^ sq_a[SQ_W][COEF_W-1];
			dv_st[0]  <= sq_st[SQ_W];
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar j = 0; j < QDIV_W; j++) begin : g_div
		logic [COEF_W:0] tp, tm, dv;
		logic            gp, gm;
		assign tp = {dv_rp[j], dv_ddp[j][MAG_W-1]};
		assign tm = {dv_rm[j], dv_ddm[j][MAG_W-1]};
		assign dv = {1'b0, dv_dvs[j]};
		assign gp = tp >= dv;
		assign gm = tm >= dv;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v[j+1] <= 1'b0;
			else if (en)
				dv_v[j+1] <= dv_v[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_ddp[j+1] <= {dv_ddp[j][MAG_W-2:0], 1'b0};
				dv_ddm[j+1] <= {dv_ddm[j][MAG_W-2:0], 1'b0};
				dv_rp[j+1]  <= gp ? COEF_W'(tp - dv) : tp[COEF_W-1:0];
				dv_rm[j+1]  <= gm ? COEF_W'(tm - dv) : tm[COEF_W-1:0];
				dv_qp[j+1]  <= {dv_qp[j][QDIV_W-2:0], gp};
				dv_qm[j+1]  <= {dv_qm[j][QDIV_W-2:0], gm};
				dv_dvs[j+1] <= dv_dvs[j];
				dv_np[j+1]  <= dv_np[j];
				dv_nm[j+1]  <= dv_nm[j];
				dv_st[j+1]  <= dv_st[j];
			end
		end
	end

	// sign and clamp to q16.16
	localparam logic [QDIV_W-1:0] POS_LIM = QDIV_W'(33'h0_7FFF_FFFF);
	localparam logic [QDIV_W-1:0] NEG_LIM = QDIV_W'(33'h0_8000_0000);

	logic [ROOT_W-1:0] rp_d, rm_d;
	logic              satp, satm;
	always_comb begin
		if (dv_np[QDIV_W]) begin
			satp = dv_qp[QDIV_W] > NEG_LIM;
			rp_d = satp ? 32'h8000_0000 : ROOT_W'(-dv_qp[QDIV_W]);
		end else begin
			satp = dv_qp[QDIV_W] > POS_LIM;
			rp_d = satp ? 32'h7FFF_FFFF : dv_qp[QDIV_W][ROOT_W-1:0];
		end
		if (dv_nm[QDIV_W]) begin
			satm = dv_qm[QDIV_W] > NEG_LIM;
			rm_d = satm ? 32'h8000_0000 : ROOT_W'(-dv_qm[QDIV_W]);
		end else begin
			satm = dv_qm[QDIV_W] > POS_LIM;
			rm_d = satm ? 32'h7FFF_FFFF : dv_qm[QDIV_W][ROOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_out_q <= 1'b0;
		else if (en)
			v_out_q <= dv_v[QDIV_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_q <= dv_st[QDIV_W];
			if (dv_st[QDIV_W] == STATUS_OK) begin
				rp_q  <= rp_d;
				rm_q  <= rm_d;
				sat_q <= satp || satm;
			end else begin
				rp_q  <= '0;
				rm_q  <= '0;
				sat_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = v_out_q;
	assign m_axis_tdata  = {rm_q, rp_q};
	assign m_axis_tuser  = {sat_q, st_q};

`ifndef NO_ASSERTIONS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && st_q != STATUS_OK |-> rp_q == '0 && rm_q == '0 && !sat_q)
		else $error("error status with nonzero roots");

	a_sat_ext: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && sat_q |-> rp_q == 32'h7FFF_FFFF || rp_q == 32'h8000_0000 ||
			rm_q == 32'h7FFF_FFFF || rm_q == 32'h8000_0000)
		else $error("saturation flag without a clamped root");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted item lost at stage one");

	a_azero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && a_s2 == '0 |-> st_s2 == STATUS_A_ZERO)
		else $error("zero coefficient a not flagged");
`endif

endmodule

>>> bench/testbench.sv
// self-checking bench for the quadratic real-root solver: directed and random coefficient sets
// with random idling on both streams; expected roots come from a bit-exact predictor
// depends on qrrs_pkg and quadratic_real_root_solver
`timescale 1ns / 100ps

module testbench;
	import qrrs_pkg::*;

	typedef struct packed {
		logic signed [ROOT_W-1:0] root_plus;
		logic signed [ROOT_W-1:0] root_minus;
		logic [STAT_W-1:0]        status;
		logic                     saturated;
	} roots_t;

	// floor square root of a non-negative value
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint clamp_root(longint v, ref logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic roots_t solve_roots(logic signed [15:0] ca, logic signed [15:0] cb,
			logic signed [15:0] cc);
		roots_t r;
		longint a, b, c, disc, s, nb, rp, rm;
		logic sat;
		a = longint'(ca);
		b = longint'(cb);
		c = longint'(cc);
		sat = 1'b0;
		r = '0;
		if (a == 0) begin
			r.status = STATUS_A_ZERO;
			return r;
		end
		disc = b * b - 4 * a * c;
		if (disc < 0) begin
			r.status = STATUS_NO_REAL;
			return r;
		end
		s = longint'(floor_sqrt(longint'(disc) << 16));
		nb = -b * 256;
		rp = ((nb + s) * 128) / a;
		rm = ((nb - s) * 128) / a;
		r.root_plus = ROOT_W'(clamp_root(rp, sat));
		r.root_minus = ROOT_W'(clamp_root(rm, sat));
		r.status = STATUS_OK;
		r.saturated = sat;
		return r;
	endfunction

	class roots_scoreboard;
		roots_t pending[$];
		int errors;
		int checked;
		int saturated_seen;
		int status_seen[3];

		function void note_coefs(logic [47:0] coefs);
			pending.push_back(solve_roots(coefs[15:0], coefs[31:16], coefs[47:32]));
		endfunction

		function void check_roots(logic [63:0] data, logic [2:0] user);
			roots_t want;
			if (pending.size() == 0) begin
				$error("result with nothing expected: data %h user %h", data, user);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (want.status < 3) status_seen[want.status]++;
			if (want.saturated) saturated_seen++;
			if (data[31:0] !== want.root_plus) begin
				$error("root_plus: expected %h, got %h", want.root_plus, data[31:0]);
				errors++;
			end
			if (data[63:32] !== want.root_minus) begin
				$error("root_minus: expected %h, got %h", want.root_minus, data[63:32]);
				errors++;
			end
			if (user[1:0] !== want.status) begin
				$error("solve_status: expected %0d, got %0d", want.status, user[1:0]);
				errors++;
			end
			if (user[2] !== want.saturated) begin
				$error("root_saturated: expected %0d, got %0d", want.saturated, user[2]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;  // coef_a, coef_b, coef_c
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;       // root_plus, root_minus
	logic [2:0]  m_axis_tuser;       // solve_status, root_saturated

	roots_scoreboard board = new();
	bit   sending_done = 0;
	bit   idle_on = 1;

	always #2 clk = ~clk;

	quadratic_real_root_solver uut (.*);

	task automatic send_coefs(logic [15:0] ca, logic [15:0] cb, logic [15:0] cc);
		int gap;
		gap = idle_on ? $urandom_range(0, 19) : 0;
		// valid stays up from the last transfer only when this one follows at once
		if (gap != 0) s_axis_tvalid <= 1'b0;
		repeat (gap) @(posedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {cc, cb, ca};
		do @(posedge clk); while (!s_axis_tready);
		board.note_coefs({cc, cb, ca});
	endtask

	function automatic logic [15:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 1023)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	// result side with random stalls
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = idle_on ? $urandom_range(0, 19) : 0;
			if (stall != 0) m_axis_tready <= 1'b0;
			repeat (stall) @(posedge clk);
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			board.check_roots(m_axis_tdata, m_axis_tuser);
		end
	end

	initial begin
		logic [15:0] ext[4];
		logic [15:0] ra;
		logic [15:0] rb;
		ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// field extremes, a zero, negative discriminant, zero discriminant
		foreach (ext[i]) send_coefs(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]);
		send_coefs(16'h0000, 16'h1234, 16'h5678);
		send_coefs(16'h0100, 16'h0000, 16'h0100);
		send_coefs(16'h0100, 16'hfe00, 16'h0100);  // double root at one
		send_coefs(16'h0100, 16'h0400, 16'h0400);  // double root at minus two
		send_coefs(16'h0001, 16'h7fff, 16'h8000);  // huge roots, saturation
		send_coefs(16'hffff, 16'h8000, 16'h7fff);
		send_coefs(16'h8000, 16'h8000, 16'h8000);
		send_coefs(16'h7fff, 16'h7fff, 16'h8000);
		send_coefs(16'h0100, 16'h0100, 16'hfa00);
		for (int n = 0; n < 1500; n++) begin
			// a burst without idling now and then
			if (n % 300 == 0) idle_on = 1;
			if (n % 300 == 200) idle_on = 0;
			ra = pick_coef();
			rb = pick_coef();
			// square-complete some sets so double roots turn up
			if ($urandom_range(0, 9) == 0 && ra != 0)
				send_coefs(16'h0100, rb & 16'h7f00, 16'((int'(signed'(rb & 16'h7f00))
					* int'(signed'(rb & 16'h7f00))) >>> 10));
			else
				send_coefs(ra, rb, pick_coef());
		end
		s_axis_tvalid <= 1'b0;
		idle_on = 1;
		wait (board.pending.size() == 0);
		repeat (200) @(posedge clk);
		$display("%0d results checked: %0d valid, %0d a zero, %0d no real root, %0d saturated",
			board.checked, board.status_seen[0], board.status_seen[1],
			board.status_seen[2], board.saturated_seen);
		if (board.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
